### src/vzd_pkg.sv
// shared types, constants and decode functions for the point varint decoder
`default_nettype none

package vzd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned VAR_W    = COORD_W + 1;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned CONT_BIT = 7;

    localparam logic [BYTE_W-1:0]  DATA_MASK   = 8'h7F;
    localparam logic [COUNT_W-1:0] LAST_BYTE   = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_ZERO  = 3'd0;

    typedef struct packed {
        logic [VAR_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic               expecting_y;
        logic [COORD_W-1:0] pending_x;
        logic [COORD_W-1:0] x_sum;
        logic [COORD_W-1:0] y_sum;
    } dec_state_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               overlong;
    } dec_result_t;

    localparam dec_state_t STATE_CLEAR = '0;

    // zigzag to two's complement, low 16 bits
    function automatic logic [COORD_W-1:0] zigzag16(input logic [VAR_W-1:0] v);
        logic [COORD_W-1:0] mag;
        mag = v[VAR_W-1:1];
        return v[0] ? ~mag : mag;
    endfunction

endpackage

`default_nettype wire

### src/vzd_step.sv
// one byte of the decode: varint assembly, zigzag, delta sums, result select
`default_nettype none

module vzd_step (
    input  wire logic [vzd_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                       feature_start,
    input  wire vzd_pkg::dec_state_t        state_cur,
    output vzd_pkg::dec_state_t             state_new,
    output vzd_pkg::dec_result_t            result
);
    import vzd_pkg::*;

    dec_state_t         st;
    logic [VAR_W-1:0]   data_ext;
    logic [VAR_W-1:0]   merged;
    logic [COORD_W-1:0] delta;

    always_comb begin
        st       = feature_start ? STATE_CLEAR : state_cur;
        data_ext = {{(VAR_W-BYTE_W){1'b0}}, byte_in & DATA_MASK};

        // shifts of 21 and 28 fall outside the kept bits
        case (st.count)
            COUNT_ZERO: merged = st.value | data_ext;
            COUNT_ONE:  merged = st.value | (data_ext << 7);
            COUNT_TWO:  merged = st.value | (data_ext << 14);
            default:    merged = st.value;
        endcase

        delta     = zigzag16(merged);
        state_new = st;
        result    = '0;

        if (byte_in[CONT_BIT]) begin
            if (st.count >= LAST_BYTE) begin
                state_new.value = '0;
                state_new.count = '0;
                result.valid    = 1'b1;
                result.overlong = 1'b1;
            end else begin
                state_new.value = merged;
                state_new.count = st.count + COUNT_ONE;
            end
        end else begin
            state_new.value = '0;
            state_new.count = '0;
            if (!st.expecting_y) begin
                state_new.pending_x   = delta;
                state_new.expecting_y = 1'b1;
            end else begin
                state_new.x_sum       = st.x_sum + st.pending_x;
                state_new.y_sum       = st.y_sum + delta;
                state_new.expecting_y = 1'b0;
                result.valid          = 1'b1;
                result.x_coord        = st.x_sum + st.pending_x;
                result.y_coord        = st.y_sum + delta;
            end
        end
    end

endmodule

`default_nettype wire

### src/varint_zigzag_delta_point_decoder.sv
// top level of the point varint decoder: input stage, decode state, result register
// usage
//   s_ channel: one raw byte of the point stream per item, with s_feature_start
//   set on the first byte of a new feature (clears sums, x/y phase, varint state)
//   m_ channel: one decoded point per completed y varint, or an error item with
//   zero coordinates when a varint still continues in its fifth byte
// flow: an accepted byte lands in the input register, is decoded combinationally
// from it and the decode state, and its point is written into the result register
// throughput: one byte per cycle; only a byte yielding a point waits on a full m_
// the decode itself is a single short pass (mask, shift, or, xor, 16-bit add)
// reset (aresetn low, synchronous) empties both stages and zeroes the sums,
// the pending x delta and the varint state
// when m_ready is low the result register holds its item; the input register
// keeps taking bytes until a byte that yields a point has to wait behind it
// s_ready then drops until the result is taken
`default_nettype none

module varint_zigzag_delta_point_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [vzd_pkg::BYTE_W-1:0]        s_byte_in,
    input  wire logic                              s_feature_start,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [vzd_pkg::COORD_W-1:0]     m_x_coord,
    output logic signed [vzd_pkg::COORD_W-1:0]     m_y_coord,
    output logic                                   m_overlong_error
);
    import vzd_pkg::*;

    // input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_fs_reg;

    // decoder state
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_res;

    // result register
    logic               m_valid_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               err_reg;

    logic out_free;
    logic advance;

    vzd_step u_step (
        .byte_in       (in_byte_reg),
        .feature_start (in_fs_reg),
        .state_cur     (state_reg),
        .state_new     (state_next),
        .result        (step_res)
    );

    // result slot free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    // a byte that yields nothing never waits on the output side
    assign advance  = in_valid_reg && (out_free || !step_res.valid);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_fs_reg   <= s_feature_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && step_res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res.valid) begin
            x_reg   <= step_res.x_coord;
            y_reg   <= step_res.y_coord;
            err_reg <= step_res.overlong;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_x_coord        = x_reg;
    assign m_y_coord        = y_reg;
    assign m_overlong_error = err_reg;

    // an error item never carries coordinates
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && err_reg |-> x_reg == '0 && y_reg == '0)
        else $error("overlong error item with nonzero coordinates");

    // the byte count never passes the fifth byte
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.count <= LAST_BYTE)
        else $error("varint byte count out of range");

    // a byte held in the input stage is neither lost nor changed
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(state_reg))
        else $error("stalled input byte dropped or state moved");

endmodule

`default_nettype wire

### sim/varint_zigzag_delta_point_decoder_tb.sv
// self-checking testbench for the point varint decoder: directed and random byte streams
module varint_zigzag_delta_point_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vzd_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 8;

    // one decoded point or an error item as the block should report it
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               err;
    } point_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [BYTE_W-1:0]         s_byte_in = '0;
    logic                      s_feature_start = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_x_coord;
    logic signed [COORD_W-1:0] m_y_coord;
    logic                      m_overlong_error;

    // points still owed by the block, oldest first
    point_t pending_points[$];

    // shadow copy of the decode state
    logic [VAR_W-1:0]   acc_value = '0;
    logic [COUNT_W-1:0] acc_count = '0;
    logic               phase_y = 1'b0;
    logic [COORD_W-1:0] held_dx = '0;
    logic [COORD_W-1:0] run_x = '0;
    logic [COORD_W-1:0] run_y = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent = 0;
    int fail_count = 0;
    bit hold_off_start = 1'b0;

    varint_zigzag_delta_point_decoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_feature_start  (s_feature_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_x_coord        (m_x_coord),
        .m_y_coord        (m_y_coord),
        .m_overlong_error (m_overlong_error)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // advance the shadow decoder by one accepted byte
    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic fs);
        logic [VAR_W-1:0]   chunk;
        logic [COORD_W-1:0] delta;
        point_t             pt;
        // a feature start wipes everything before the byte is used
        if (fs) begin
            acc_value = '0;
            acc_count = '0;
            phase_y = 1'b0;
            held_dx = '0;
            run_x = '0;
            run_y = '0;
        end
        // only the first three bytes can reach the 17 kept bits
        if (acc_count <= COUNT_TWO) begin
            chunk = VAR_W'(b & DATA_MASK);
            acc_value = acc_value | (chunk << (7 * acc_count));
        end
        if (b[CONT_BIT]) begin
            // fifth byte still continuing: error item, varint restarts
            if (acc_count >= LAST_BYTE) begin
                acc_value = '0;
                acc_count = '0;
                pt = '{x: '0, y: '0, err: 1'b1};
                pending_points.push_back(pt);
            end else begin
                acc_count = acc_count + COUNT_ONE;
            end
        end else begin
            // zigzag: low bit selects the sign, the rest is the magnitude
            delta = acc_value[0] ? ~acc_value[VAR_W-1:1] : acc_value[VAR_W-1:1];
            acc_value = '0;
            acc_count = '0;
            if (!phase_y) begin
                held_dx = delta;
                phase_y = 1'b1;
            end else begin
                run_x = run_x + held_dx;
                run_y = run_y + delta;
                phase_y = 1'b0;
                pt = '{x: run_x, y: run_y, err: 1'b0};
                pending_points.push_back(pt);
            end
        end
    endfunction

    // offer one byte, with random idle cycles first, and wait for the handshake
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= b;
        s_feature_start <= fs;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b, fs);
        bytes_sent++;
    endtask

    // leb128 encoding of a value; fs goes on the first byte only
    task automatic send_value(input logic [31:0] v, input logic fs);
        logic [BYTE_W-1:0] b;
        logic              first_fs;
        first_fs = fs;
        do begin
            b = BYTE_W'(v & DATA_MASK);
            v = v >> 7;
            if (v != 0) b[CONT_BIT] = 1'b1;
            send_byte(b, first_fs);
            first_fs = 1'b0;
        end while (v != 0);
    endtask

    // varint of random content; overlong keeps the continuation bit on all five bytes
    task automatic send_varint(input int len, input bit overlong, input logic fs);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            b = BYTE_W'($urandom_range(0, 127));
            if (overlong || i < len - 1) b[CONT_BIT] = 1'b1;
            send_byte(b, fs && i == 0);
        end
    endtask

    // drop valid and wait until every owed point has been taken
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // zero points, the largest deltas of both signs and wrap of the sums
    task automatic test_points_and_wrap();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_value(0, 1'b1);
        send_value(0, 1'b0);
        // +32767 and -32768, then the same again so both sums wrap
        repeat (2) begin
            send_value(32'd65534, 1'b0);
            send_value(32'd65535, 1'b0);
        end
        wait_drained();
    endtask

    // a five-byte varint that just fits as the x, all data bits set; a one-byte y follows
    task automatic test_wide_varint();
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b0);
        wait_drained();
    endtask

    // overlong varint while a y is due: error item, x delta survives
    task automatic test_overlong();
        send_value(3, 1'b1);
        repeat (5) send_byte(8'h80 | 8'h7F, 1'b0);
        send_value(4, 1'b0);
        wait_drained();
    endtask

    // feature start in the middle of a varint throws the partial bytes away
    task automatic test_feature_restart();
        send_byte(8'h85, 1'b0);
        send_byte(8'h05, 1'b1);
        send_value(6, 1'b0);
        wait_drained();
    endtask

    // mostly well-formed features of random points, plus overlong runs and noise
    task automatic test_random(input int n_bytes, input int send_pct, input int recv_pct);
        int start;
        int pick;
        int npts;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                npts = $urandom_range(1, 8);
                for (int p = 0; p < 2 * npts; p++) begin
                    if ($urandom_range(19) == 0)
                        send_varint(5, 1'b1, p == 0);
                    else
                        send_varint(($urandom_range(9) < 7) ? $urandom_range(1, 2)
                                                            : $urandom_range(3, 5),
                                    1'b0, p == 0);
                end
            end else if (pick < 90) begin
                send_varint(5, 1'b1, 1'b0);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(7) == 0);
            end
        end
        wait_drained();
    endtask

    // receiver stops for a long stretch while bytes keep coming, so s_ready drops
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        hold_off_start = 1'b1;
        send_value(0, 1'b1);
        repeat (20) send_varint($urandom_range(1, 2), 1'b0, 1'b0);
        wait_drained();
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        int hold_left;
        if (hold_off_start) begin
            hold_left = HOLD_CYCLES;
            hold_off_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each taken item against the oldest owed point
    always @(posedge aclk) begin
        point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected item: x %0d y %0d err %0b",
                       m_x_coord, m_y_coord, m_overlong_error);
                fail_count++;
            end else begin
                want = pending_points.pop_front();
                if (m_x_coord !== want.x) begin
                    $error("x_coord expected %0d got %0d", $signed(want.x), m_x_coord);
                    fail_count++;
                end
                if (m_y_coord !== want.y) begin
                    $error("y_coord expected %0d got %0d", $signed(want.y), m_y_coord);
                    fail_count++;
                end
                if (m_overlong_error !== want.err) begin
                    $error("overlong_error expected %0b got %0b", want.err, m_overlong_error);
                    fail_count++;
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #(6_000_000);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        // synchronous reset, released on a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_points_and_wrap();
        test_wide_varint();
        test_overlong();
        test_feature_restart();
        test_random(520, 10, 48);
        test_random(520, 48, 10);
        test_backpressure();
        test_random(520, 0, 0);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
